// File: rtl/mfd_pkg.sv
// Shared types, constants and the CRC-32 byte update for the marker frame deframer.
package mfd_pkg;

   // Framing geometry
   localparam int WinLen    = 14;
   localparam int MarkLen   = 10;
   localparam int HeaderLen = 7;
   localparam int FillW     = $clog2(WinLen + 1);
   localparam int PcountW   = 14;
   localparam logic [PcountW-1:0] PcountTop = '1;

   // Sample limits
   localparam int MaxSamples = 4096;
   localparam int KeptW      = 13;
   localparam int IndexW     = 12;

   // Result queue
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // CRC-32, reflected
   localparam logic [31:0] CrcPoly = 32'hEDB88320;
   localparam logic [31:0] CrcInit = 32'hFFFFFFFF;

   localparam logic [7:0] MarkPattern [MarkLen] = '{
      8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h01
   };

   typedef enum logic {
      KIND_SAMPLE = 1'b0,
      KIND_END    = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_CRC_BAD  = 2'd1,
      STATUS_SHORT    = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      kind_type           kind;
      logic [IndexW-1:0]  sample_index;
      logic signed [15:0] sample_value;
      logic [31:0]        frame_stamp;
      logic [7:0]         probe_type;
      logic [15:0]        encoder_position;
      logic [KeptW-1:0]   sample_count;
      status_type         frame_status;
      logic               last;
   } result_type;

   // Fold one byte into the running CRC register, LSB first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/mfd_core.sv
// Deframer datapath: delay window, marker match, header capture, samples and CRC check.
module mfd_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   output logic                   sample_push,
   output mfd_pkg::result_type    sample_res,
   output logic                   end_push,
   output mfd_pkg::result_type    end_res
);

   logic [7:0]                  win_ff [mfd_pkg::WinLen];
   logic [7:0]                  win_in [mfd_pkg::WinLen];
   logic [mfd_pkg::FillW-1:0]   fill_ff, fill_in, fill_step;
   logic                        in_frame_ff, in_frame_in;
   logic [mfd_pkg::PcountW-1:0] pcount_ff, pcount_in, pcount_step;
   logic [31:0]                 stamp_ff, stamp_in, stamp_step;
   logic [7:0]                  probe_ff, probe_in, probe_step;
   logic [15:0]                 enc_ff, enc_in, enc_step;
   logic [7:0]                  hold_ff, hold_in, hold_step;
   logic [mfd_pkg::KeptW-1:0]   kept_ff, kept_in, kept_step;
   logic [31:0]                 crc_ff, crc_in, crc_step;
   logic                        ovf_ff, ovf_in, ovf_step;

   logic       take;
   logic [7:0] old_byte;
   logic       mark_hit;
   logic       too_short;
   logic [31:0] got_crc;
   mfd_pkg::status_type status;

   // Shift the window and bump the fill count
   always_comb begin
      for (int i = 0; i < mfd_pkg::WinLen - 1; i++) begin
         win_in[i] = win_ff[i+1];
      end
      win_in[mfd_pkg::WinLen-1] = data_byte;
      fill_step = (fill_ff < mfd_pkg::FillW'(mfd_pkg::WinLen)) ? fill_ff + 1'b1 : fill_ff;
   end

   // Consume the byte leaving the window
   assign old_byte = win_ff[0];
   assign take     = (fill_ff == mfd_pkg::FillW'(mfd_pkg::WinLen)) && in_frame_ff;

   always_comb begin
      stamp_step  = stamp_ff;
      probe_step  = probe_ff;
      enc_step    = enc_ff;
      hold_step   = hold_ff;
      kept_step   = kept_ff;
      ovf_step    = ovf_ff;
      crc_step    = crc_ff;
      pcount_step = pcount_ff;
      sample_push = 1'b0;
      if (take) begin
         crc_step = mfd_pkg::crc_byte(crc_ff, old_byte);
         if (pcount_ff < mfd_pkg::PcountW'(4)) begin
            stamp_step = {stamp_ff[23:0], old_byte};
         end else if (pcount_ff == mfd_pkg::PcountW'(4)) begin
            probe_step = old_byte;
         end else if (pcount_ff < mfd_pkg::PcountW'(mfd_pkg::HeaderLen)) begin
            enc_step = {enc_ff[7:0], old_byte};
         end else if (pcount_ff[0]) begin
            // odd count after a seven-byte header: high byte of a sample
            hold_step = old_byte;
         end else if (kept_ff < mfd_pkg::KeptW'(mfd_pkg::MaxSamples)) begin
            sample_push = 1'b1;
            kept_step   = kept_ff + 1'b1;
         end else begin
            ovf_step = 1'b1;
         end
         // saturate near the top, keeping the high/low alternation
         pcount_step = (pcount_ff == mfd_pkg::PcountTop) ? pcount_ff - 1'b1
                                                        : pcount_ff + 1'b1;
      end
   end

   // Match the marker at the tail of the window
   always_comb begin
      mark_hit = (fill_step >= mfd_pkg::FillW'(mfd_pkg::MarkLen));
      for (int i = 0; i < mfd_pkg::MarkLen; i++) begin
         if (win_in[mfd_pkg::WinLen-mfd_pkg::MarkLen+i] != mfd_pkg::MarkPattern[i]) begin
            mark_hit = 1'b0;
         end
      end
   end

   // Judge the frame that the marker closes
   assign got_crc   = {win_in[0], win_in[1], win_in[2], win_in[3]};
   assign too_short = (fill_step != mfd_pkg::FillW'(mfd_pkg::WinLen)) ||
                      (pcount_step < mfd_pkg::PcountW'(mfd_pkg::HeaderLen));

   always_comb begin
      if (too_short) begin
         status = mfd_pkg::STATUS_SHORT;
      end else if (got_crc != ~crc_step) begin
         status = mfd_pkg::STATUS_CRC_BAD;
      end else if (ovf_step) begin
         status = mfd_pkg::STATUS_OVERFLOW;
      end else begin
         status = mfd_pkg::STATUS_OK;
      end
   end

   assign end_push = mark_hit && in_frame_ff;

   // Build the result beats
   always_comb begin
      sample_res              = '0;
      sample_res.kind         = mfd_pkg::KIND_SAMPLE;
      sample_res.sample_index = kept_ff[mfd_pkg::IndexW-1:0];
      sample_res.sample_value = {hold_ff, old_byte};
      sample_res.frame_status = mfd_pkg::STATUS_OK;
      sample_res.last         = !end_push;

      end_res                  = '0;
      end_res.kind             = mfd_pkg::KIND_END;
      end_res.frame_stamp      = stamp_step;
      end_res.probe_type       = probe_step;
      end_res.encoder_position = enc_step;
      end_res.sample_count     = kept_step;
      end_res.frame_status     = status;
      end_res.last             = 1'b1;
   end

   // Clear frame state on every marker
   always_comb begin
      in_frame_in = in_frame_ff;
      fill_in     = fill_step;
      pcount_in   = pcount_step;
      stamp_in    = stamp_step;
      probe_in    = probe_step;
      enc_in      = enc_step;
      hold_in     = hold_step;
      kept_in     = kept_step;
      crc_in      = crc_step;
      ovf_in      = ovf_step;
      if (mark_hit) begin
         in_frame_in = 1'b1;
         fill_in     = '0;
         pcount_in   = '0;
         stamp_in    = '0;
         probe_in    = '0;
         enc_in      = '0;
         hold_in     = '0;
         kept_in     = '0;
         crc_in      = mfd_pkg::CrcInit;
         ovf_in      = 1'b0;
      end
   end

   // Hold the window bytes; fill gates every read of them
   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < mfd_pkg::WinLen; i++) begin
            win_ff[i] <= win_in[i];
         end
      end
   end

   // Advance frame state per accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         in_frame_ff <= 1'b0;
         pcount_ff   <= '0;
         stamp_ff    <= '0;
         probe_ff    <= '0;
         enc_ff      <= '0;
         hold_ff     <= '0;
         kept_ff     <= '0;
         crc_ff      <= mfd_pkg::CrcInit;
         ovf_ff      <= 1'b0;
      end else if (accept) begin
         fill_ff     <= fill_in;
         in_frame_ff <= in_frame_in;
         pcount_ff   <= pcount_in;
         stamp_ff    <= stamp_in;
         probe_ff    <= probe_in;
         enc_ff      <= enc_in;
         hold_ff     <= hold_in;
         kept_ff     <= kept_in;
         crc_ff      <= crc_in;
         ovf_ff      <= ovf_in;
      end
   end

   // Window fill never passes its depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= mfd_pkg::FillW'(mfd_pkg::WinLen))
      else $error("window fill out of range");

   // Samples come only from inside a frame
   a_sample_in_frame: assert property (@(posedge clock) disable iff (reset)
      sample_push |-> in_frame_ff && (pcount_ff >= mfd_pkg::PcountW'(mfd_pkg::HeaderLen)))
      else $error("sample outside frame payload");

   // Kept count never exceeds the sample limit
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      kept_ff <= mfd_pkg::KeptW'(mfd_pkg::MaxSamples))
      else $error("kept samples over limit");

   // A marker always restarts the window
   a_mark_restart: assert property (@(posedge clock) disable iff (reset)
      accept && mark_hit |=> fill_ff == '0 && in_frame_ff)
      else $error("marker did not restart frame");

endmodule

// File: rtl/mfd_rsp_fifo.sv
// Small result queue: up to two beats written per cycle, one beat read.
module mfd_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_a,
   input  mfd_pkg::result_type data_a,
   input  logic                push_b,
   input  mfd_pkg::result_type data_b,
   output logic                room_two,
   output logic                out_valid,
   input  logic                out_stall,
   output mfd_pkg::result_type out_data
);

   mfd_pkg::result_type          mem_ff [mfd_pkg::QueueDepth];
   logic [mfd_pkg::QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mfd_pkg::QueueCntW-1:0] count_ff, count_in;
   logic [mfd_pkg::QueuePtrW-1:0] b_addr;
   logic                          pop;

   assign pop       = out_valid && !out_stall;
   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign room_two  = (count_ff <= mfd_pkg::QueueCntW'(mfd_pkg::QueueDepth - 2));
   assign b_addr    = wr_ptr_ff + mfd_pkg::QueuePtrW'(push_a);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + mfd_pkg::QueuePtrW'(push_a) + mfd_pkg::QueuePtrW'(push_b);
      rd_ptr_in = rd_ptr_ff + mfd_pkg::QueuePtrW'(pop);
      count_in  = count_ff + mfd_pkg::QueueCntW'(push_a) + mfd_pkg::QueueCntW'(push_b)
                  - mfd_pkg::QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store beats in order
   always_ff @(posedge clock) begin
      if (push_a) begin
         mem_ff[wr_ptr_ff] <= data_a;
      end
      if (push_b) begin
         mem_ff[b_addr] <= data_b;
      end
   end

   // Occupancy stays within depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mfd_pkg::QueueCntW'(mfd_pkg::QueueDepth))
      else $error("result queue overflow");

   // Pushes only land when there was room for both
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push_a || push_b) |-> room_two)
      else $error("push without room");

   // Pointers and count agree
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == mfd_pkg::QueueCntW'(mfd_pkg::QueueDepth))
      == (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");

endmodule

// File: rtl/marker_framed_packet_deframer_crc32.sv
// Top level of the marker framed deframer with CRC-32 check.
// Takes one stream byte per cycle and answers with sample beats and frame-end beats.
// A byte is treated as frame data only after 14 more bytes have arrived, so samples
// trail the stream by 14 bytes; the frame-end beat for a frame appears when the
// closing 00 01 x5 marker completes. Results are registered in a four-beat result
// queue and show on the rsp_ port from its head. The block takes a new byte every
// cycle as long as the queue has room for two beats (a byte can cause a sample and
// a frame end together); req_stall rises only when the result side holds off long
// enough for three or more beats to wait in the queue.
module marker_framed_packet_deframer_crc32 (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_data_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_kind,
   output logic [11:0]                rsp_sample_index,
   output logic signed [15:0]         rsp_sample_value,
   output logic [31:0]                rsp_frame_stamp,
   output logic [7:0]                 rsp_probe_type,
   output logic [15:0]                rsp_encoder_position,
   output logic [12:0]                rsp_sample_count,
   output logic [1:0]                 rsp_frame_status,
   output logic                       rsp_last
);

   logic                accept;
   logic                room_two;
   logic                sample_push, end_push;
   mfd_pkg::result_type sample_res, end_res, head;

   // Take a beat only when the queue can absorb two results
   assign req_stall = !room_two;
   assign accept    = req_valid && !req_stall;

   mfd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .sample_push (sample_push),
      .sample_res  (sample_res),
      .end_push    (end_push),
      .end_res     (end_res)
   );

   mfd_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_a    (accept && sample_push),
      .data_a    (sample_res),
      .push_b    (accept && end_push),
      .data_b    (end_res),
      .room_two  (room_two),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   // Unpack the head beat onto the result ports
   assign rsp_kind             = head.kind;
   assign rsp_sample_index     = head.sample_index;
   assign rsp_sample_value     = head.sample_value;
   assign rsp_frame_stamp      = head.frame_stamp;
   assign rsp_probe_type       = head.probe_type;
   assign rsp_encoder_position = head.encoder_position;
   assign rsp_sample_count     = head.sample_count;
   assign rsp_frame_status     = head.frame_status;
   assign rsp_last             = head.last;

endmodule

// File: tb/deframe_checker.sv
// Result checker for the marker framed deframer: tracks the byte stream and compares beats.
module deframe_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [7:0]         req_data_byte,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_kind,
   input  logic [11:0]        rsp_sample_index,
   input  logic signed [15:0] rsp_sample_value,
   input  logic [31:0]        rsp_frame_stamp,
   input  logic [7:0]         rsp_probe_type,
   input  logic [15:0]        rsp_encoder_position,
   input  logic [12:0]        rsp_sample_count,
   input  logic [1:0]         rsp_frame_status,
   input  logic               rsp_last,
   output int                 mismatches,
   output int                 beats_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          WindowBytes = 14;
   localparam int          MarkerBytes = 10;
   localparam int          HeaderBytes = 7;
   localparam logic [31:0] Crc32Poly   = 32'hEDB88320;

   // Shadow of the deframer state
   logic [7:0]  win [WindowBytes];
   int          fill;
   bit          framing;
   logic [13:0] pay_pos;
   logic [31:0] stamp;
   logic [7:0]  probe;
   logic [15:0] enc;
   logic [7:0]  hi_byte;
   logic [12:0] kept;
   logic [31:0] crc;
   bit          dropped;

   // Beats predicted but not yet seen on the result port
   mfd_pkg::result_type beats_due [$];

   task automatic clear_frame();
      pay_pos = '0;
      stamp   = '0;
      probe   = '0;
      enc     = '0;
      hi_byte = '0;
      kept    = '0;
      crc     = '1;
      dropped = 1'b0;
   endtask

   always @(posedge clock) begin : track
      mfd_pkg::result_type beat;
      mfd_pkg::result_type want;
      mfd_pkg::result_type step_beats [2];
      int                  n_step;
      logic [7:0]          b;
      logic [31:0]         sent_crc;
      bit                  on_marker;
      if (reset) begin
         foreach (win[k]) win[k] = 8'h00;
         fill       = 0;
         framing    = 1'b0;
         clear_frame();
         beats_due  = {};
         mismatches = 0;
      end else begin
         // Predict: one byte in, up to two beats out
         if (req_valid && !req_stall) begin
            n_step = 0;
            // Oldest window byte becomes frame data
            if (fill >= WindowBytes && framing) begin
               b   = win[0];
               crc = crc ^ {24'd0, b};
               for (int k = 0; k < 8; k++) begin
                  crc = crc[0] ? ((crc >> 1) ^ Crc32Poly) : (crc >> 1);
               end
               if (pay_pos < 4) begin
                  stamp = {stamp[23:0], b};
               end else if (pay_pos == 4) begin
                  probe = b;
               end else if (pay_pos < HeaderBytes) begin
                  enc = {enc[7:0], b};
               end else if (pay_pos[0]) begin
                  // odd position past the header: high byte of a sample
                  hi_byte = b;
               end else if (kept < mfd_pkg::MaxSamples) begin
                  beat              = '0;
                  beat.kind         = mfd_pkg::KIND_SAMPLE;
                  beat.sample_index = kept[11:0];
                  beat.sample_value = {hi_byte, b};
                  step_beats[n_step] = beat;
                  n_step++;
                  kept++;
               end else begin
                  dropped = 1'b1;
               end
               // saturate near the top, keeping the high/low alternation
               pay_pos = (pay_pos == '1) ? pay_pos - 14'd1 : pay_pos + 14'd1;
            end
            // Advance the window
            for (int k = 0; k < WindowBytes - 1; k++) win[k] = win[k + 1];
            win[WindowBytes - 1] = req_data_byte;
            if (fill < WindowBytes) fill++;
            // Marker: the newest ten bytes alternate 00 01, all after the last marker
            on_marker = (fill >= MarkerBytes);
            for (int k = 0; k < MarkerBytes; k++) begin
               if (win[WindowBytes - MarkerBytes + k] != 8'(k % 2)) on_marker = 1'b0;
            end
            if (on_marker) begin
               if (framing) begin
                  beat                  = '0;
                  beat.kind             = mfd_pkg::KIND_END;
                  beat.frame_stamp      = stamp;
                  beat.probe_type       = probe;
                  beat.encoder_position = enc;
                  beat.sample_count     = kept;
                  sent_crc              = {win[0], win[1], win[2], win[3]};
                  if (fill < WindowBytes || pay_pos < HeaderBytes) begin
                     beat.frame_status = mfd_pkg::STATUS_SHORT;
                  end else if (sent_crc != ~crc) begin
                     beat.frame_status = mfd_pkg::STATUS_CRC_BAD;
                  end else if (dropped) begin
                     beat.frame_status = mfd_pkg::STATUS_OVERFLOW;
                  end else begin
                     beat.frame_status = mfd_pkg::STATUS_OK;
                  end
                  step_beats[n_step] = beat;
                  n_step++;
               end
               framing = 1'b1;
               fill    = 0;
               clear_frame();
            end
            // Flag the final beat of this byte
            if (n_step != 0) step_beats[n_step - 1].last = 1'b1;
            for (int k = 0; k < n_step; k++) beats_due.insert(beats_due.size(), step_beats[k]);
         end

         // Compare the accepted beat with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (beats_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("%0t: result beat with none pending: kind=%0d idx=%0d cnt=%0d",
                           $time, rsp_kind, rsp_sample_index, rsp_sample_count);
               end
            end else begin
               want = beats_due.pop_front();
               if (rsp_kind !== want.kind || rsp_sample_index !== want.sample_index ||
                   rsp_sample_value !== want.sample_value ||
                   rsp_frame_stamp !== want.frame_stamp || rsp_probe_type !== want.probe_type ||
                   rsp_encoder_position !== want.encoder_position ||
                   rsp_sample_count !== want.sample_count ||
                   rsp_frame_status !== want.frame_status || rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: result beat mismatch", $time);
                     $display("  want kind=%0d idx=%0d val=%0d ts=%h pt=%h enc=%h",
                              want.kind, want.sample_index, want.sample_value,
                              want.frame_stamp, want.probe_type, want.encoder_position);
                     $display("       cnt=%0d st=%0d last=%0d",
                              want.sample_count, want.frame_status, want.last);
                     $display("  got  kind=%0d idx=%0d val=%0d ts=%h pt=%h enc=%h",
                              rsp_kind, rsp_sample_index, rsp_sample_value,
                              rsp_frame_stamp, rsp_probe_type, rsp_encoder_position);
                     $display("       cnt=%0d st=%0d last=%0d",
                              rsp_sample_count, rsp_frame_status, rsp_last);
                  end
               end
            end
         end
      end
      beats_owed = beats_due.size();
   end

endmodule

// File: tb/tb_top.sv
// Testbench top for the marker framed deframer: byte stream stimulus, flow control and verdict.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          ClockPeriod    = 10;
   localparam int          ResetCycles    = 11;
   localparam int          StreamBytes    = 1850;
   localparam int          TailBytes      = 120;
   localparam int          HeaderBytes    = 7;
   localparam int          LongHoldCycles = 300;
   localparam int          DrainCycles    = 40;
   localparam int          CycleLimit     = 200000;
   localparam logic [31:0] Crc32Poly      = 32'hEDB88320;

   typedef enum logic [1:0] {
      FILL_RANDOM,
      FILL_ZERO,
      FILL_ONES,
      FILL_EDGES
   } fill_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [7:0]         req_data_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_kind;
   logic [11:0]        rsp_sample_index;
   logic signed [15:0] rsp_sample_value;
   logic [31:0]        rsp_frame_stamp;
   logic [7:0]         rsp_probe_type;
   logic [15:0]        rsp_encoder_position;
   logic [12:0]        rsp_sample_count;
   logic [1:0]         rsp_frame_status;
   logic               rsp_last;
   int                 mismatches;
   int                 beats_owed;

   logic gap_stall = 1'b0;
   logic long_hold = 1'b0;
   bit   quiet_req = 1'b0;
   int   bytes_taken = 0;
   int   cycle_count = 0;

   assign rsp_stall = gap_stall | long_hold;

   marker_framed_packet_deframer_crc32 u_top (.*);

   deframe_checker u_check (.*);

   always #(ClockPeriod / 2) clock = ~clock;

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("[marker_framed_packet_deframer_crc32] ERROR");
         $finish;
      end
   end

   function automatic logic [7:0] rand_byte();
      logic [7:0] corners [5] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
      if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 4)];
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] pick_byte(input fill_type mode, input int pos);
      // sample pairs 7FFF, 8000, 0000, FFFF once past the header
      logic [7:0] edges [8] = '{8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
      case (mode)
         FILL_ZERO:  return 8'h00;
         FILL_ONES:  return 8'hFF;
         FILL_EDGES: return edges[(pos + 1) % 8];
         default:    return rand_byte();
      endcase
   endfunction

   // Offer one byte after a random gap and hold it until taken
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = quiet_req ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data_byte = b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_taken++;
      @(negedge clock);
   endtask

   task automatic send_marker();
      for (int k = 0; k < 10; k++) send_byte(8'(k % 2));
   endtask

   // Arbitrary body bytes closed by a marker
   task automatic send_raw_frame(input int len);
      repeat (len) send_byte(rand_byte());
      send_marker();
   endtask

   // Header, samples, optional odd byte, CRC (big-endian), closing marker
   task automatic send_frame(input int n_samples, input bit crc_good, input bit odd_tail,
                             input fill_type mode);
      logic [7:0]  body [$];
      logic [31:0] crc;
      crc = 32'hFFFF_FFFF;
      for (int i = 0; i < HeaderBytes + 2 * n_samples + int'(odd_tail); i++) begin
         body.insert(body.size(), pick_byte(mode, i));
      end
      foreach (body[i]) begin
         crc = crc ^ {24'd0, body[i]};
         repeat (8) crc = crc[0] ? ((crc >> 1) ^ Crc32Poly) : (crc >> 1);
      end
      crc = ~crc;
      if (!crc_good) crc = crc ^ (32'd1 << $urandom_range(0, 31));
      foreach (body[i]) send_byte(body[i]);
      for (int k = 3; k >= 0; k--) send_byte(crc[8 * k +: 8]);
      send_marker();
   endtask

   // Result side: random stall ahead of each beat, with quiet stretches
   initial begin : result_side
      int unsigned wait_n;
      int          beats_seen;
      bit          quiet_rsp;
      beats_seen = 0;
      quiet_rsp  = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (beats_seen % 40 == 0) quiet_rsp = ($urandom_range(0, 3) == 0);
         wait_n = quiet_rsp ? 0 : $urandom_range(0, 5);
         if (wait_n != 0) begin
            gap_stall = 1'b1;
            repeat (wait_n) @(negedge clock);
         end
         gap_stall = 1'b0;
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         beats_seen++;
         @(negedge clock);
      end
   end

   // Long hold-offs so the result queue fills and the input stalls
   initial begin : long_hold_off
      for (int i = 0; i < 2; i++) begin
         wait (bytes_taken >= 400 + 800 * i);
         @(negedge clock);
         long_hold = 1'b1;
         repeat (LongHoldCycles) @(negedge clock);
         long_hold = 1'b0;
      end
   end

   initial begin : stimulus
      int       pick;
      int       shade;
      int       n_samples;
      fill_type mode;

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Leading junk with a near-miss marker, then the first marker
      repeat (4) begin
         send_byte(8'h00);
         send_byte(8'h01);
      end
      send_byte(8'h00);
      send_byte(8'hFF);
      send_marker();
      // Back-to-back markers: empty frame
      send_marker();
      // Overlapping marker: twelve bytes of 00 01, earliest match wins
      send_byte(8'h00);
      send_byte(8'h01);
      send_marker();
      // Header but no room for a CRC
      send_raw_frame(8);
      send_frame(0, 1'b1, 1'b0, FILL_ONES);
      send_frame(2, 1'b1, 1'b0, FILL_ZERO);
      send_frame(4, 1'b1, 1'b1, FILL_EDGES);
      send_frame(3, 1'b0, 1'b0, FILL_RANDOM);

      // Mostly well-formed frames with random content, some broken ones and noise
      while (bytes_taken < StreamBytes - TailBytes) begin
         quiet_req = ($urandom_range(0, 4) == 0);
         pick      = $urandom_range(0, 99);
         if (pick < 70) begin
            shade     = $urandom_range(0, 19);
            mode      = (shade == 0) ? FILL_ZERO : (shade == 1) ? FILL_ONES :
                        (shade == 2) ? FILL_EDGES : FILL_RANDOM;
            n_samples = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                    : $urandom_range(0, 12);
            send_frame(n_samples, $urandom_range(0, 99) < 85, $urandom_range(0, 4) == 0, mode);
         end else if (pick < 80) begin
            send_raw_frame($urandom_range(0, 10));
         end else if (pick < 88) begin
            // partial markers inside a frame
            repeat ($urandom_range(1, 4)) begin
               send_byte(8'h00);
               send_byte(8'h01);
            end
            send_byte(rand_byte());
            send_marker();
         end else if (pick < 94) begin
            send_byte(8'h00);
            send_byte(8'h01);
            send_marker();
         end else begin
            send_raw_frame($urandom_range(11, 40));
         end
      end

      // Closing frame, then an unterminated final frame
      quiet_req = 1'b0;
      send_frame(3, 1'b1, 1'b0, FILL_RANDOM);
      repeat (25) send_byte(rand_byte());
      req_valid = 1'b0;

      // Drain
      while (beats_owed != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (mismatches == 0 && beats_owed == 0) begin
         $display("[marker_framed_packet_deframer_crc32] OK");
      end else begin
         $display("[marker_framed_packet_deframer_crc32] ERROR");
      end
      $finish;
   end

endmodule
